// File: rtl/assert_macros.svh
// Assertion macros shared by the vsync deadline generator RTL.
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/vdg_pkg.sv
// Package of the vsync deadline generator: mode and register codes, widths,
// controller states, datapath commands and status. No dependencies.
`default_nettype none
package vdg_pkg;
	localparam int TIME_W   = 64;
	localparam int IN_W     = 63;
	localparam int PERIOD_W = 30;
	localparam int CFG_W    = 30;

	localparam logic [1:0] MODE_SOFT = 2'd0;
	localparam logic [1:0] MODE_MIX  = 2'd1;
	localparam logic [1:0] MODE_HW   = 2'd2;

	localparam logic [1:0] REG_SYNC_MODE = 2'd0;
	localparam logic [1:0] REG_PERIOD    = 2'd1;
	localparam logic [1:0] REG_DISPLAY   = 2'd2;
	localparam logic [1:0] REG_TUNNEL    = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_REALIGN_WAIT,
		S_SOFT_STEP,
		S_SOFT_CHECK,
		S_MISS_WAIT,
		S_MIX_WAIT,
		S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SOFT_PREP,
		OP_REALIGN,
		OP_SOFT_STEP,
		OP_MISS_FIX,
		OP_MIX_REBASE,
		OP_MIX_STEP,
		OP_HW,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		DIV_REALIGN,
		DIV_MISS,
		DIV_MIX
	} div_sel_t;

	typedef struct packed {
		op_t      op;
		logic     div_start;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       drop;
		logic       realign;
		logic       missed;
		logic       mix_rebase;
		logic       div_done;
	} status_t;
endpackage
`default_nettype wire

// File: rtl/vdg_div.sv
// Iterative unsigned remainder unit: 64-bit dividend, 30-bit divisor,
// two quotient bits per cycle. Depends on vdg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module vdg_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [vdg_pkg::TIME_W-1:0]     dividend,
	input  wire logic [vdg_pkg::PERIOD_W-1:0]   divisor,
	output logic                                done,
	output logic [vdg_pkg::PERIOD_W-1:0]        rem
);
	localparam int ITER   = vdg_pkg::TIME_W / 2;
	localparam int CNT_W  = $clog2(ITER);

	logic [vdg_pkg::TIME_W-1:0]   dvd_q;
	logic [vdg_pkg::PERIOD_W-1:0] rem_q;
	logic [vdg_pkg::PERIOD_W-1:0] div_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [vdg_pkg::PERIOD_W:0]   t1, t2;
	logic [vdg_pkg::PERIOD_W-1:0] r1, r2;

	// Two restoring steps per cycle; each partial remainder stays below the divisor.
	always_comb begin
		t1 = {rem_q, dvd_q[vdg_pkg::TIME_W-1]};
		r1 = (t1 >= {1'b0, div_q}) ? vdg_pkg::PERIOD_W'(t1 - {1'b0, div_q})
		                           : t1[vdg_pkg::PERIOD_W-1:0];
		t2 = {r1, dvd_q[vdg_pkg::TIME_W-2]};
		r2 = (t2 >= {1'b0, div_q}) ? vdg_pkg::PERIOD_W'(t2 - {1'b0, div_q})
		                           : t2[vdg_pkg::PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ITER - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[vdg_pkg::TIME_W-3:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`ASSERT_NEVER(a_start_busy, clk, arst_n, start && busy_q, "divider restarted while busy")
	`ASSERT_AR(a_rem_range, clk, arst_n, done_q |-> (rem_q < div_q), "remainder not below divisor")
endmodule
`default_nettype wire

// File: rtl/vdg_datapath.sv
// Datapath: configuration registers, timing state, remainder unit and
// result registers. Depends on vdg_pkg, vdg_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module vdg_datapath #(
	parameter int unsigned DEFAULT_RATE_HZ = 60,
	parameter int unsigned MIX_OFFSET_NS   = 5000000
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [vdg_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [vdg_pkg::IN_W-1:0]     now_time,
	input  wire logic [vdg_pkg::IN_W-1:0]     vblank_time,
	input  wire logic                         vblank_error,
	input  wire vdg_pkg::cmd_t                cmd,
	output vdg_pkg::status_t                  status,
	output logic [vdg_pkg::IN_W-1:0]          vsync_stamp,
	output logic signed [vdg_pkg::TIME_W-1:0] measured_period,
	output logic                              notify_display,
	output logic                              notify_tunnel,
	output logic                              wait_failed
);
	localparam int TW = vdg_pkg::TIME_W;
	localparam int PW = vdg_pkg::PERIOD_W;
	localparam logic [PW-1:0] DEF_PERIOD = PW'(1000000000 / DEFAULT_RATE_HZ);
	localparam logic [TW-1:0] MIX_OFF    = TW'(MIX_OFFSET_NS);

	// Configuration and timing state.
	logic [1:0]    mode_q;
	logic [PW-1:0] req_q;
	logic          disp_q;
	logic          tun_q;
	logic [TW-1:0] sd_q;
	logic [PW-1:0] slp_q;
	logic [TW-1:0] hbt_q;
	logic [PW-1:0] mlp_q;
	logic          armed_q;
	logic [TW-1:0] prev_q;
	logic          neg_q;

	// Captured input word.
	logic [vdg_pkg::IN_W-1:0] now_q;
	logic [vdg_pkg::IN_W-1:0] vblank_q;
	logic                     err_q;

	logic [TW-1:0] now_ext;
	logic [TW-1:0] vbl_ext;
	logic [PW-1:0] p_soft;
	logic [PW-1:0] p_mix;
	logic [TW-1:0] miss_diff;
	logic [TW-1:0] dividend;
	logic [TW-1:0] magnitude;
	logic [PW-1:0] divisor;
	logic [PW-1:0] rem;
	logic          div_done;
	logic [TW-1:0] srem;
	logic [TW-1:0] stamp;
	logic          hw_mode;
	logic          failed;

	assign now_ext   = {1'b0, now_q};
	assign vbl_ext   = {1'b0, vblank_q};
	assign p_soft    = (req_q == '0) ? DEF_PERIOD : req_q;
	assign p_mix     = (mlp_q == '0) ? DEF_PERIOD : mlp_q;
	assign miss_diff = sd_q - now_ext;
	assign hw_mode   = (mode_q != vdg_pkg::MODE_SOFT) && (mode_q != vdg_pkg::MODE_MIX);
	assign failed    = hw_mode && err_q;
	assign stamp     = (mode_q == vdg_pkg::MODE_SOFT) ? sd_q : hbt_q;

	// Remainders are truncating, so a negative distance gets a negative remainder.
	always_comb begin
		dividend = (cmd.div_sel == vdg_pkg::DIV_MIX) ? now_ext - hbt_q : now_ext - sd_q;
		magnitude = dividend[TW-1] ? -dividend : dividend;
		case (cmd.div_sel)
			vdg_pkg::DIV_REALIGN: divisor = slp_q;
			vdg_pkg::DIV_MISS:    divisor = req_q;
			default:              divisor = p_mix;
		endcase
		srem = neg_q ? -{{(TW-PW){1'b0}}, rem} : {{(TW-PW){1'b0}}, rem};
	end

	vdg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (magnitude),
		.divisor  (divisor),
		.done     (div_done),
		.rem      (rem)
	);

	always_comb begin
		status.mode       = mode_q;
		status.drop       = !disp_q && !tun_q;
		status.realign    = (p_soft != slp_q) && (slp_q != '0);
		status.missed     = miss_diff[TW-1];
		status.mix_rebase = (mlp_q != req_q) || armed_q;
		status.div_done   = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= vdg_pkg::MODE_SOFT;
			req_q   <= '0;
			disp_q  <= 1'b0;
			tun_q   <= 1'b0;
			sd_q    <= '0;
			slp_q   <= '0;
			hbt_q   <= '0;
			mlp_q   <= '0;
			armed_q <= 1'b0;
			prev_q  <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				neg_q <= dividend[TW-1];
			end
			case (cmd.op)
				vdg_pkg::OP_SOFT_PREP: begin
					// A zero period is replaced by the default for good.
					req_q <= p_soft;
					if (slp_q == '0) begin
						slp_q <= p_soft;
					end
				end
				vdg_pkg::OP_REALIGN: begin
					sd_q  <= now_ext - srem;
					slp_q <= req_q;
				end
				vdg_pkg::OP_SOFT_STEP: sd_q <= sd_q + {{(TW-PW){1'b0}}, req_q};
				vdg_pkg::OP_MISS_FIX: sd_q <= now_ext + {{(TW-PW){1'b0}}, req_q} - srem;
				vdg_pkg::OP_MIX_REBASE: begin
					hbt_q   <= vbl_ext + MIX_OFF;
					mlp_q   <= req_q;
					armed_q <= 1'b0;
				end
				vdg_pkg::OP_MIX_STEP: hbt_q <= now_ext + {{(TW-PW){1'b0}}, p_mix} - srem;
				vdg_pkg::OP_HW: hbt_q <= vbl_ext;
				vdg_pkg::OP_FINISH: prev_q <= stamp;
				default: ;
			endcase
			if (cfg_write) begin
				unique case (cfg_index)
					vdg_pkg::REG_SYNC_MODE: begin
						mode_q <= cfg_data[1:0];
						if (cfg_data[1:0] == vdg_pkg::MODE_MIX) begin
							armed_q <= 1'b1;
						end
					end
					vdg_pkg::REG_PERIOD:  req_q  <= cfg_data;
					vdg_pkg::REG_DISPLAY: disp_q <= cfg_data[0];
					vdg_pkg::REG_TUNNEL:  tun_q  <= cfg_data[0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == vdg_pkg::OP_LOAD) begin
			now_q    <= now_time;
			vblank_q <= vblank_time;
			err_q    <= vblank_error;
		end
		if (cmd.op == vdg_pkg::OP_FINISH) begin
			vsync_stamp     <= stamp[vdg_pkg::IN_W-1:0];
			measured_period <= (prev_q != '0) ? $signed(stamp - prev_q)
			                                  : $signed({{(TW-PW){1'b0}}, req_q});
			notify_display  <= disp_q && !failed;
			notify_tunnel   <= tun_q && !failed;
			wait_failed     <= failed;
		end
	end

	`ASSERT_AR(a_realign_period, clk, arst_n, (cmd.op == vdg_pkg::OP_REALIGN) |=> (slp_q == req_q), "realign left a stale period")
	`ASSERT_AR(a_miss_ahead, clk, arst_n, (cmd.op == vdg_pkg::OP_MISS_FIX) |=> ($signed(sd_q - now_ext) > 0), "re-phased deadline not ahead of now")
endmodule
`default_nettype wire

// File: rtl/vdg_ctrl.sv
// Controller state machine: sequences one word through the datapath and
// owns the handshakes. Depends on vdg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module vdg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire vdg_pkg::status_t status,
	output vdg_pkg::cmd_t         cmd
);
	vdg_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign in_ready = (state_q == vdg_pkg::S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vdg_pkg::S_IDLE: begin
				// A word arriving with both consumers disabled is dropped here.
				if (in_valid && !status.drop) begin
					state_d = vdg_pkg::S_DISPATCH;
				end
			end
			vdg_pkg::S_DISPATCH: begin
				unique case (status.mode)
					vdg_pkg::MODE_SOFT:
						state_d = status.realign ? vdg_pkg::S_REALIGN_WAIT
						                         : vdg_pkg::S_SOFT_STEP;
					vdg_pkg::MODE_MIX:
						state_d = status.mix_rebase ? vdg_pkg::S_FINISH
						                            : vdg_pkg::S_MIX_WAIT;
					default: state_d = vdg_pkg::S_FINISH;
				endcase
			end
			vdg_pkg::S_REALIGN_WAIT: begin
				if (status.div_done) begin
					state_d = vdg_pkg::S_SOFT_STEP;
				end
			end
			vdg_pkg::S_SOFT_STEP: state_d = vdg_pkg::S_SOFT_CHECK;
			vdg_pkg::S_SOFT_CHECK:
				state_d = status.missed ? vdg_pkg::S_MISS_WAIT : vdg_pkg::S_FINISH;
			vdg_pkg::S_MISS_WAIT: begin
				if (status.div_done) begin
					state_d = vdg_pkg::S_FINISH;
				end
			end
			vdg_pkg::S_MIX_WAIT: begin
				if (status.div_done) begin
					state_d = vdg_pkg::S_FINISH;
				end
			end
			vdg_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = vdg_pkg::S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		cmd.op        = vdg_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = vdg_pkg::DIV_REALIGN;
		unique case (state_q)
			vdg_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.op = vdg_pkg::OP_LOAD;
				end
			end
			vdg_pkg::S_DISPATCH: begin
				unique case (status.mode)
					vdg_pkg::MODE_SOFT: begin
						cmd.op        = vdg_pkg::OP_SOFT_PREP;
						cmd.div_start = status.realign;
						cmd.div_sel   = vdg_pkg::DIV_REALIGN;
					end
					vdg_pkg::MODE_MIX: begin
						cmd.div_sel = vdg_pkg::DIV_MIX;
						if (status.mix_rebase) begin
							cmd.op = vdg_pkg::OP_MIX_REBASE;
						end else begin
							cmd.div_start = 1'b1;
						end
					end
					default: cmd.op = vdg_pkg::OP_HW;
				endcase
			end
			vdg_pkg::S_REALIGN_WAIT: begin
				if (status.div_done) begin
					cmd.op = vdg_pkg::OP_REALIGN;
				end
			end
			vdg_pkg::S_SOFT_STEP: cmd.op = vdg_pkg::OP_SOFT_STEP;
			vdg_pkg::S_SOFT_CHECK: begin
				cmd.div_start = status.missed;
				cmd.div_sel   = vdg_pkg::DIV_MISS;
			end
			vdg_pkg::S_MISS_WAIT: begin
				cmd.div_sel = vdg_pkg::DIV_MISS;
				if (status.div_done) begin
					cmd.op = vdg_pkg::OP_MISS_FIX;
				end
			end
			vdg_pkg::S_MIX_WAIT: begin
				cmd.div_sel = vdg_pkg::DIV_MIX;
				if (status.div_done) begin
					cmd.op = vdg_pkg::OP_MIX_STEP;
				end
			end
			vdg_pkg::S_FINISH: begin
				if (out_free) begin
					cmd.op = vdg_pkg::OP_FINISH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vdg_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == vdg_pkg::OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_AR(a_finish_out, clk, arst_n, (state_q == vdg_pkg::S_FINISH && out_free) |=> (out_valid_q && state_q == vdg_pkg::S_IDLE), "finished word not presented")
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready && cmd.op == vdg_pkg::OP_FINISH, "pending result overwritten")
endmodule
`default_nettype wire

// File: rtl/vsync_deadline_generator.sv
// Vsync deadline generator, top level: joins the controller and datapath.
// Depends on vdg_pkg, vdg_ctrl, vdg_datapath (which holds vdg_div).
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one wake-up word: now_time,
//    vblank_time and vblank_error. Output channel (out_valid/out_ready)
//    returns at most one word per input: vsync_stamp, measured_period and
//    the notify and wait_failed flags.
//  - Configuration is a plain write port (cfg_write, cfg_index, cfg_data):
//    0 sync_mode, 1 requested_period, 2 display_enable, 3 tunnel_enable.
//    Write it only while the block is idle.
//  - A word arriving while both enables are low is accepted and dropped.
//  - One word is processed at a time; in_ready is high while idle.
//    The path from accept to out_valid depends on the case: hardware mode
//    and a mix rebase go straight from dispatch to the final step; a
//    software step that stays on schedule adds a step and a check state;
//    mix extrapolation, a software period change and a missed deadline
//    each add a run of the remainder unit, which retires two bits per cycle.
//  - The result sits in an output register; while the receiver stalls the
//    block holds the finished word and accepts the next input, and it
//    stops at its final step until the register is free.
//  - Reset zeroes config and timing state, not input or result registers.
`default_nettype none
module vsync_deadline_generator #(
	parameter int unsigned DEFAULT_RATE_HZ = 60,
	parameter int unsigned MIX_OFFSET_NS   = 5000000
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [vdg_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [vdg_pkg::IN_W-1:0]     now_time,
	input  wire logic [vdg_pkg::IN_W-1:0]     vblank_time,
	input  wire logic                         vblank_error,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [vdg_pkg::IN_W-1:0]          vsync_stamp,
	output logic signed [vdg_pkg::TIME_W-1:0] measured_period,
	output logic                              notify_display,
	output logic                              notify_tunnel,
	output logic                              wait_failed
);
	vdg_pkg::cmd_t    cmd;
	vdg_pkg::status_t status;

	vdg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	vdg_datapath #(
		.DEFAULT_RATE_HZ (DEFAULT_RATE_HZ),
		.MIX_OFFSET_NS   (MIX_OFFSET_NS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.now_time        (now_time),
		.vblank_time     (vblank_time),
		.vblank_error    (vblank_error),
		.cmd             (cmd),
		.status          (status),
		.vsync_stamp     (vsync_stamp),
		.measured_period (measured_period),
		.notify_display  (notify_display),
		.notify_tunnel   (notify_tunnel),
		.wait_failed     (wait_failed)
	);
endmodule
`default_nettype wire
